>>> rtl/rce_pkg.sv
// package: shared types and constants of the reward curve evaluator
package rce_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ValW  = 2 * WordW;
  localparam int unsigned PosW  = $clog2(ValW);
  localparam int unsigned NumCells = ValW;

  typedef enum logic [1:0] {
    OP_QUAD     = 2'd0,
    OP_CURATION = 2'd1,
    OP_LINEAR   = 2'd2,
    OP_SQRT     = 2'd3
  } op_e;

  typedef enum logic {
    CFG_CONST_HI = 1'b0,
    CFG_CONST_LO = 1'b1
  } cfg_idx_e;

  // data carried from cell to cell
  typedef struct packed {
    op_e              op;
    logic             dz;
    logic             found;
    logic [PosW-1:0]  m;
    logic [ValW-1:0]  x;
    logic [ValW-1:0]  acc;
    logic [ValW-1:0]  q;
    logic [ValW-1:0]  d;
  } cell_data_t;

endpackage

>>> rtl/rce_if.sv
// interfaces: share count request channel and curve value channel
interface rce_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [rce_pkg::WordW-1:0]   rshares_hi;
  logic [rce_pkg::WordW-1:0]   rshares_lo;
  modport source (output valid, op, rshares_hi, rshares_lo, input ready);
  modport sink   (input valid, op, rshares_hi, rshares_lo, output ready);
endinterface

interface rce_out_if;
  logic                        valid;
  logic                        ready;
  logic [rce_pkg::WordW-1:0]   result_hi;
  logic [rce_pkg::WordW-1:0]   result_lo;
  logic                        divide_by_zero;
  modport source (output valid, result_hi, result_lo, divide_by_zero, input ready);
  modport sink   (input valid, result_hi, result_lo, divide_by_zero, output ready);
endinterface

>>> rtl/reward_curve_evaluator_top.sv
// top level: reward curve evaluator built as a chain of step cells
//
//  channel   dir  contents
//  in_i      in   op, rshares_hi, rshares_lo
//  out_o     out  result_hi, result_lo, divide_by_zero
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// every request passes 128 cells, one bit of product, quotient or leading-one
// search per cell, and one request enters per cycle unless the chain stalls.
// the last cell is the output register; when it holds an untaken result the
// whole chain stalls, otherwise a new request is taken every cycle.
// reset clears the valid bits and both curve constant registers.
module reward_curve_evaluator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rce_pkg::WordW-1:0] cfg_data_i,
  rce_in_if.sink                    in_i,
  rce_out_if.source                 out_o
);

  localparam int unsigned WordW    = rce_pkg::WordW;
  localparam int unsigned ValW     = rce_pkg::ValW;
  localparam int unsigned PosW     = rce_pkg::PosW;
  localparam int unsigned NumCells = rce_pkg::NumCells;

  logic [WordW-1:0] cc_hi_q, cc_lo_q;
  logic             en;
  logic [ValW-1:0]  r, dsum;
  rce_pkg::cell_data_t entry;
  rce_pkg::cell_data_t chain [NumCells+1];
  logic                vld   [NumCells+1];
  rce_pkg::cell_data_t last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_hi_q <= '0;
      cc_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (rce_pkg::cfg_idx_e'(cfg_idx_i))
        rce_pkg::CFG_CONST_HI: cc_hi_q <= cfg_data_i;
        rce_pkg::CFG_CONST_LO: cc_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chain advances unless a result waits at the output
  assign en         = !vld[NumCells] || out_o.ready;
  assign in_i.ready = en;

  // entry: (r+s)^2 - s^2 == r*(r+2s), and r+2s is also the curation divisor
  always_comb begin
    r     = {in_i.rshares_hi, in_i.rshares_lo};
    dsum  = {cc_hi_q[WordW-2:0], cc_lo_q, 1'b0} + r;
    entry = '0;
    entry.op = rce_pkg::op_e'(in_i.op);
    case (rce_pkg::op_e'(in_i.op))
      rce_pkg::OP_QUAD: begin
        entry.x = r;
        entry.d = dsum;
      end
      rce_pkg::OP_CURATION: begin
        entry.x  = {in_i.rshares_lo, {WordW{1'b0}}};
        entry.d  = dsum;
        entry.dz = (dsum == '0);
      end
      default: begin
        entry.x = r;
        entry.d = r;
      end
    endcase
  end

  assign chain[0] = entry;
  assign vld[0]   = in_i.valid;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rce_cell #(.Idx(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[k]),
      .data_i  (chain[k]),
      .valid_o (vld[k+1]),
      .data_o  (chain[k+1])
    );
  end

  assign last = chain[NumCells];

  // final selection, square root built from the leading-one position
  logic [PosW-1:0]  m, sh;
  logic [PosW-2:0]  h;
  logic [ValW-1:0]  mant, res;
  logic [WordW-1:0] hb, zhi, z, sq;

  always_comb begin
    m    = last.m;
    h    = m[PosW-1:1];
    sh   = m - {1'b0, h};
    mant = last.d & ((ValW'(1) << m) - ValW'(1));
    z    = WordW'(mant >> sh);
    hb   = WordW'(1) << h;
    zhi  = m[0] ? hb : '0;
    sq   = last.found ? (hb | ((zhi | z) >> 1)) : '0;
    case (last.op)
      rce_pkg::OP_QUAD:     res = last.acc;
      rce_pkg::OP_CURATION: res = last.dz ? '0 : last.q;
      rce_pkg::OP_LINEAR:   res = last.d;
      rce_pkg::OP_SQRT:     res = {{WordW{1'b0}}, sq};
      default:              res = '0;
    endcase
  end

  assign out_o.valid          = vld[NumCells];
  assign out_o.result_hi      = res[ValW-1:WordW];
  assign out_o.result_lo      = res[WordW-1:0];
  assign out_o.divide_by_zero = last.op == rce_pkg::OP_CURATION && last.dz;

  // a held result stays valid and its lower word stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.result_lo))
    else $error("held result changed");

  // a new request is refused only while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("chain stalled without cause");

  // square root never reaches the upper word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && last.op == rce_pkg::OP_SQRT |-> out_o.result_hi == '0)
    else $error("square root upper word set");

endmodule

>>> rtl/rce_cell.sv
// cell: one shift-add, restoring divide or leading-one step per request; linear passes through
module rce_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rce_pkg::cell_data_t data_i,
  output logic                valid_o,
  output rce_pkg::cell_data_t data_o
);

  localparam int unsigned ValW = rce_pkg::ValW;

  logic                valid_q;
  rce_pkg::cell_data_t data_q, data_d;
  logic [ValW-1:0]     rem_sh, diff;
  logic                take;

  // one step of whichever curve the request selects
  always_comb begin
    data_d = data_i;
    rem_sh = {data_i.acc[ValW-2:0], data_i.x[ValW-1]};
    diff   = rem_sh - data_i.d;
    take   = data_i.acc[ValW-1] | (rem_sh >= data_i.d);
    data_d.x = {data_i.x[ValW-2:0], 1'b0};
    case (data_i.op)
      rce_pkg::OP_QUAD: begin
        data_d.acc = {data_i.acc[ValW-2:0], 1'b0} +
                     (data_i.x[ValW-1] ? data_i.d : '0);
      end
      rce_pkg::OP_CURATION: begin
        data_d.acc = take ? diff : rem_sh;
        data_d.q   = {data_i.q[ValW-2:0], take};
      end
      rce_pkg::OP_SQRT: begin
        if (!data_i.found && data_i.x[ValW-1]) begin
          data_d.found = 1'b1;
          data_d.m     = rce_pkg::PosW'(ValW - 1 - Idx);
        end
      end
      default: ;
    endcase
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
